>>> design/ttb_pkg.sv
// Shared types and constants for the triangle tangent and bitangent unit.
`default_nettype none
package ttb_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned DIFF_W  = COORD_W + 1;
   localparam int unsigned PROD_W  = 2 * DIFF_W;
   localparam int unsigned TERM_W  = PROD_W + 1;
   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned NORM_W  = 30;
   localparam int unsigned SUM_W   = 62;
   localparam int unsigned ROOT_W  = 31;
   localparam int unsigned QUOT_W  = 16;
   localparam int unsigned FRAC_W  = 14;
   localparam int unsigned CNT_W   = 5;

   localparam logic [UNIT_W-1:0] ONE_Q14 = UNIT_W'(16384);

   localparam logic [2:0] MUL_LAST  = 3'd7;
   localparam logic [2:0] SQ_LAST   = 3'd3;
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(30);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(15);
   localparam logic [1:0] COMP_LAST = 2'd2;
   localparam logic [1:0] SLOT_THIRD = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_NLOAD,
      ST_NORM,
      ST_SQ,
      ST_SINIT,
      ST_SQRT,
      ST_DINIT,
      ST_DIV,
      ST_QSTORE,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic       load;
      logic [1:0] slot;
      logic       mul;
      logic       nload;
      logic       shr;
      logic       shl;
      logic       sq;
      logic       sinit;
      logic       sqrt;
      logic       dinit;
      logic       div;
      logic       qstore;
      logic       fin;
      logic [2:0] idx;
      logic       vsel;
      logic [1:0] comp;
      logic       valid;
      logic       deg;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
      logic vec_zero;
      logic too_big;
      logic too_small;
   } stat_type;

endpackage
`default_nettype wire

>>> design/ttb_if.sv
// Handshake channel interfaces for corner input and tangent result.
`default_nettype none
interface ttb_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  pos_x;
   logic signed [31:0]  pos_y;
   logic signed [31:0]  pos_z;
   logic signed [31:0]  tex_u;
   logic signed [31:0]  tex_v;
   logic                has_uv;
   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, has_uv, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, has_uv, output ready);
endinterface

interface ttb_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  tangent_x;
   logic signed [15:0]  tangent_y;
   logic signed [15:0]  tangent_z;
   logic signed [15:0]  bitangent_x;
   logic signed [15:0]  bitangent_y;
   logic signed [15:0]  bitangent_z;
   logic                tangent_valid;
   logic                degenerate;
   modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                   bitangent_z, tangent_valid, degenerate, input ready);
   modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                 bitangent_z, tangent_valid, degenerate, output ready);
endinterface
`default_nettype wire

>>> design/ttb_ctrl.sv
// Sequencing state machine for the tangent unit.
`default_nettype none
module ttb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_has_uv,
   output logic                   req_ready,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   input  wire ttb_pkg::stat_type st,
   output ttb_pkg::cmd_type       cmd
);

   ttb_pkg::state_type state_ff, state_in;
   logic [ttb_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic       vsel_ff, vsel_in;
   logic [1:0] comp_ff, comp_in;
   logic [1:0] count_ff, count_in;
   logic       valid_ff, valid_in;
   logic       deg_ff, deg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       fin_fire;

   assign accept    = (state_ff == ttb_pkg::ST_IDLE) && req_valid;
   assign fin_fire  = (state_ff == ttb_pkg::ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ttb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      vsel_in      = vsel_ff;
      comp_in      = comp_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      deg_in       = deg_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         ttb_pkg::ST_IDLE: begin
            if (accept) begin
               if (count_ff < ttb_pkg::SLOT_THIRD) begin
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in = '0;
                  cnt_in   = '0;
                  vsel_in  = 1'b0;
                  if (req_has_uv) begin
                     state_in = ttb_pkg::ST_MUL;
                  end else begin
                     valid_in = 1'b0;
                     deg_in   = 1'b0;
                     state_in = ttb_pkg::ST_FIN;
                  end
               end
            end
         end
         ttb_pkg::ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == ttb_pkg::MUL_LAST) begin
               state_in = ttb_pkg::ST_CHECK;
            end
         end
         ttb_pkg::ST_CHECK: begin
            if (st.det_zero) begin
               valid_in = 1'b1;
               deg_in   = 1'b1;
               state_in = ttb_pkg::ST_FIN;
            end else begin
               state_in = ttb_pkg::ST_NLOAD;
            end
         end
         ttb_pkg::ST_NLOAD: begin
            state_in = ttb_pkg::ST_NORM;
         end
         ttb_pkg::ST_NORM: begin
            if (st.vec_zero) begin
               valid_in = 1'b1;
               deg_in   = 1'b1;
               state_in = ttb_pkg::ST_FIN;
            end else if (!st.too_big && !st.too_small) begin
               cnt_in   = '0;
               state_in = ttb_pkg::ST_SQ;
            end
         end
         ttb_pkg::ST_SQ: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == ttb_pkg::SQ_LAST) begin
               state_in = ttb_pkg::ST_SINIT;
            end
         end
         ttb_pkg::ST_SINIT: begin
            cnt_in   = '0;
            state_in = ttb_pkg::ST_SQRT;
         end
         ttb_pkg::ST_SQRT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ttb_pkg::SQRT_LAST) begin
               comp_in  = '0;
               state_in = ttb_pkg::ST_DINIT;
            end
         end
         ttb_pkg::ST_DINIT: begin
            cnt_in   = '0;
            state_in = ttb_pkg::ST_DIV;
         end
         ttb_pkg::ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ttb_pkg::DIV_LAST) begin
               state_in = ttb_pkg::ST_QSTORE;
            end
         end
         ttb_pkg::ST_QSTORE: begin
            if (comp_ff != ttb_pkg::COMP_LAST) begin
               comp_in  = comp_ff + 2'd1;
               state_in = ttb_pkg::ST_DINIT;
            end else if (!vsel_ff) begin
               vsel_in  = 1'b1;
               state_in = ttb_pkg::ST_NLOAD;
            end else begin
               valid_in = 1'b1;
               deg_in   = 1'b0;
               state_in = ttb_pkg::ST_FIN;
            end
         end
         ttb_pkg::ST_FIN: begin
            if (fin_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ttb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.slot  = count_ff;
      cmd.idx   = cnt_ff[2:0];
      cmd.vsel  = vsel_ff;
      cmd.comp  = comp_ff;
      cmd.valid = valid_ff;
      cmd.deg   = deg_ff;
      case (state_ff)
         ttb_pkg::ST_IDLE:   cmd.load   = accept;
         ttb_pkg::ST_MUL:    cmd.mul    = 1'b1;
         ttb_pkg::ST_NLOAD:  cmd.nload  = 1'b1;
         ttb_pkg::ST_NORM: begin
            cmd.shr = !st.vec_zero && st.too_big;
            cmd.shl = !st.vec_zero && !st.too_big && st.too_small;
         end
         ttb_pkg::ST_SQ:     cmd.sq     = 1'b1;
         ttb_pkg::ST_SINIT:  cmd.sinit  = 1'b1;
         ttb_pkg::ST_SQRT:   cmd.sqrt   = 1'b1;
         ttb_pkg::ST_DINIT:  cmd.dinit  = 1'b1;
         ttb_pkg::ST_DIV:    cmd.div    = 1'b1;
         ttb_pkg::ST_QSTORE: cmd.qstore = 1'b1;
         ttb_pkg::ST_FIN:    cmd.fin    = fin_fire;
         default:            cmd.load   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttb_pkg::ST_IDLE;
         cnt_ff       <= '0;
         vsel_ff      <= 1'b0;
         comp_ff      <= '0;
         count_ff     <= '0;
         valid_ff     <= 1'b0;
         deg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vsel_ff      <= vsel_in;
         comp_ff      <= comp_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         deg_ff       <= deg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> design/ttb_dp.sv
// Arithmetic datapath: corner store, products, normalisation, square root, division.
`default_nettype none
module ttb_dp (
   input  wire logic                clock,
   input  wire ttb_pkg::cmd_type    cmd,
   input  wire logic signed [31:0]  pos_x,
   input  wire logic signed [31:0]  pos_y,
   input  wire logic signed [31:0]  pos_z,
   input  wire logic signed [31:0]  tex_u,
   input  wire logic signed [31:0]  tex_v,
   output ttb_pkg::stat_type        st,
   output logic signed [15:0]       tangent_x,
   output logic signed [15:0]       tangent_y,
   output logic signed [15:0]       tangent_z,
   output logic signed [15:0]       bitangent_x,
   output logic signed [15:0]       bitangent_y,
   output logic signed [15:0]       bitangent_z,
   output logic                     tangent_valid,
   output logic                     degenerate
);

   localparam int unsigned DW = ttb_pkg::DIFF_W;
   localparam int unsigned PW = ttb_pkg::PROD_W;
   localparam int unsigned TW = ttb_pkg::TERM_W;
   localparam int unsigned NW = ttb_pkg::NORM_W;
   localparam int unsigned SW = ttb_pkg::SUM_W;
   localparam int unsigned RW = ttb_pkg::ROOT_W;
   localparam int unsigned QW = ttb_pkg::QUOT_W;
   localparam int unsigned FW = ttb_pkg::FRAC_W;
   localparam int unsigned UW = ttb_pkg::UNIT_W;
   localparam int unsigned XW = NW + FW + 1;

   logic signed [31:0]    pos_ff [2][3];
   logic signed [31:0]    tex_ff [2][2];
   logic signed [DW-1:0]  e1_ff [3];
   logic signed [DW-1:0]  e2_ff [3];
   logic signed [DW-1:0]  d1u_ff, d1v_ff, d2u_ff, d2v_ff;
   logic signed [PW-1:0]  p0_ff, p1_ff;
   logic signed [TW-1:0]  res_ff [7];
   logic [TW-1:0]         mag_ff [3];
   logic                  neg_ff [3];
   logic [2*NW-1:0]       sq_ff;
   logic [SW-1:0]         sum_ff;
   logic [SW-1:0]         rem_ff, root_ff, bit_ff;
   logic [RW-1:0]         drem_ff;
   logic [QW-1:0]         dnum_ff;
   logic [UW-1:0]         q_ff [2][3];
   logic [UW-1:0]         out_ff [2][3];
   logic                  out_valid_ff, out_deg_ff;

   logic signed [31:0]    pin [3];
   logic signed [DW-1:0]  op_a, op_b, op_c, op_d;
   logic [TW-1:0]         mag_or;
   logic [NW-1:0]         m_sel;
   logic [SW-1:0]         sq_try;
   logic [XW-1:0]         num;
   logic [RW:0]           dtry;
   logic [QW-1:0]         q_clamp;
   logic [1:0]            ci;

   assign pin[0] = pos_x;
   assign pin[1] = pos_y;
   assign pin[2] = pos_z;
   assign ci     = (cmd.idx[1:0] == 2'd3) ? 2'd0 : cmd.idx[1:0];

   // Operand selection: determinant first, then tangent and bitangent components.
   always_comb begin
      op_a = d1u_ff;
      op_b = d2v_ff;
      op_c = d2u_ff;
      op_d = d1v_ff;
      if (cmd.idx >= 3'd1 && cmd.idx <= 3'd3) begin
         op_a = d2v_ff;
         op_b = e1_ff[cmd.idx[1:0] - 2'd1];
         op_c = d1v_ff;
         op_d = e2_ff[cmd.idx[1:0] - 2'd1];
      end else if (cmd.idx >= 3'd4 && cmd.idx <= 3'd6) begin
         op_a = d1u_ff;
         op_b = e2_ff[2'(cmd.idx - 3'd4)];
         op_c = d2u_ff;
         op_d = e1_ff[2'(cmd.idx - 3'd4)];
      end
   end

   assign mag_or       = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign st.det_zero  = (res_ff[0] == '0);
   assign st.vec_zero  = (mag_or == '0);
   assign st.too_big   = |mag_or[TW-1:NW];
   assign st.too_small = !mag_or[NW-1];

   assign m_sel   = mag_ff[cmd.comp][NW-1:0];
   assign sq_try  = root_ff + bit_ff;
   assign num     = {1'b0, m_sel, {FW{1'b0}}} + XW'(root_ff[RW-1:1]);
   assign dtry    = {drem_ff, dnum_ff[QW-1]};
   assign q_clamp = (dnum_ff > QW'(ttb_pkg::ONE_Q14)) ? QW'(ttb_pkg::ONE_Q14) : dnum_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (cmd.slot < ttb_pkg::SLOT_THIRD) begin
            for (int i = 0; i < 3; i++) pos_ff[cmd.slot[0]][i] <= pin[i];
            tex_ff[cmd.slot[0]][0] <= tex_u;
            tex_ff[cmd.slot[0]][1] <= tex_v;
         end else begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= DW'(pos_ff[1][i]) - DW'(pos_ff[0][i]);
               e2_ff[i] <= DW'(pin[i]) - DW'(pos_ff[0][i]);
            end
            d1u_ff <= DW'(tex_ff[1][0]) - DW'(tex_ff[0][0]);
            d1v_ff <= DW'(tex_ff[1][1]) - DW'(tex_ff[0][1]);
            d2u_ff <= DW'(tex_u) - DW'(tex_ff[0][0]);
            d2v_ff <= DW'(tex_v) - DW'(tex_ff[0][1]);
         end
      end

      // Two products are registered; their difference is registered in the next cycle.
      if (cmd.mul) begin
         if (cmd.idx != ttb_pkg::MUL_LAST) begin
            p0_ff <= op_a * op_b;
            p1_ff <= op_c * op_d;
         end
         if (cmd.idx != 3'd0) begin
            res_ff[cmd.idx - 3'd1] <= TW'(p0_ff) - TW'(p1_ff);
         end
      end

      if (cmd.nload) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= res_ff[1 + 3 * int'(cmd.vsel) + i][TW-1];
            mag_ff[i] <= res_ff[1 + 3 * int'(cmd.vsel) + i][TW-1]
                         ? TW'(-res_ff[1 + 3 * int'(cmd.vsel) + i])
                         : TW'(res_ff[1 + 3 * int'(cmd.vsel) + i]);
         end
      end else if (cmd.shr) begin
         for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
      end else if (cmd.shl) begin
         for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
      end

      if (cmd.sq) begin
         if (cmd.idx != ttb_pkg::SQ_LAST) begin
            sq_ff <= mag_ff[ci][NW-1:0] * mag_ff[ci][NW-1:0];
         end
         if (cmd.idx == 3'd1) begin
            sum_ff <= SW'(sq_ff);
         end else if (cmd.idx != 3'd0) begin
            sum_ff <= sum_ff + SW'(sq_ff);
         end
      end

      // Integer square root, two bits of the radicand per step.
      if (cmd.sinit) begin
         rem_ff  <= sum_ff;
         root_ff <= '0;
         bit_ff  <= SW'(1) << (SW - 2);
      end else if (cmd.sqrt) begin
         if (rem_ff >= sq_try) begin
            rem_ff  <= rem_ff - sq_try;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      // Restoring division; the upper numerator bits are already below the divisor.
      if (cmd.dinit) begin
         drem_ff <= RW'(num[XW-1:QW]);
         dnum_ff <= num[QW-1:0];
      end else if (cmd.div) begin
         if (dtry >= {1'b0, root_ff[RW-1:0]}) begin
            drem_ff <= RW'(dtry - {1'b0, root_ff[RW-1:0]});
            dnum_ff <= {dnum_ff[QW-2:0], 1'b1};
         end else begin
            drem_ff <= dtry[RW-1:0];
            dnum_ff <= {dnum_ff[QW-2:0], 1'b0};
         end
      end

      if (cmd.qstore) begin
         q_ff[cmd.vsel][cmd.comp] <= (neg_ff[cmd.comp] != res_ff[0][TW-1])
                                     ? UW'(-q_clamp) : UW'(q_clamp);
      end

      if (cmd.fin) begin
         out_valid_ff <= cmd.valid;
         out_deg_ff   <= cmd.deg;
         for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
               out_ff[v][i] <= (cmd.valid && !cmd.deg) ? q_ff[v][i] : '0;
            end
         end
      end
   end

   assign tangent_x     = out_ff[0][0];
   assign tangent_y     = out_ff[0][1];
   assign tangent_z     = out_ff[0][2];
   assign bitangent_x   = out_ff[1][0];
   assign bitangent_y   = out_ff[1][1];
   assign bitangent_z   = out_ff[1][2];
   assign tangent_valid = out_valid_ff;
   assign degenerate    = out_deg_ff;

endmodule
`default_nettype wire

>>> design/triangle_tangent_bitangent.sv
// Top level of the triangle tangent and bitangent unit.
//
// Corners arrive on the req_chan channel, one transfer each: position and texture
// coordinates in signed Q16.16 and a has_uv flag. Every third corner closes a
// triangle and yields one transfer on rsp_chan: unit tangent and bitangent in
// signed Q2.14 with tangent_valid and degenerate flags. The first two corners
// are stored and produce nothing; the input stays ready after each of them.
// For the third corner the unit first forms products on a pair of 33 by 33
// multipliers, then for each vector runs a shift normalisation, a sum of
// squares, a square root and three divisions. Without texture coordinates the
// arithmetic is skipped and the unit goes straight to the result; a zero
// determinant ends the work after the products and a zero tangent at its
// normalisation, while a zero bitangent is only found once the tangent is done.
// The input is not ready while a triangle is in work. The result sits in an
// output register: the next triangle's corners are taken while it waits, and a
// finished triangle waits in turn if the receiver stalls. Reset clears the corner
// count and the output valid; stored corners are not cleared.
`default_nettype none
module triangle_tangent_bitangent (
   input  wire logic  clock,
   input  wire logic  reset,
   ttb_req_if.sink    req_chan,
   ttb_rsp_if.source  rsp_chan
);

   ttb_pkg::cmd_type  cmd;
   ttb_pkg::stat_type st;

   ttb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_has_uv (req_chan.has_uv),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .st         (st),
      .cmd        (cmd)
   );

   ttb_dp u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .pos_x         (req_chan.pos_x),
      .pos_y         (req_chan.pos_y),
      .pos_z         (req_chan.pos_z),
      .tex_u         (req_chan.tex_u),
      .tex_v         (req_chan.tex_v),
      .st            (st),
      .tangent_x     (rsp_chan.tangent_x),
      .tangent_y     (rsp_chan.tangent_y),
      .tangent_z     (rsp_chan.tangent_z),
      .bitangent_x   (rsp_chan.bitangent_x),
      .bitangent_y   (rsp_chan.bitangent_y),
      .bitangent_z   (rsp_chan.bitangent_z),
      .tangent_valid (rsp_chan.tangent_valid),
      .degenerate    (rsp_chan.degenerate)
   );

endmodule
`default_nettype wire

>>> design/ttb_chk.sv
// Port-level checks for the tangent unit, bound to the top level.
`default_nettype none
module ttb_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_tx,
   input wire logic [15:0] rsp_by,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_deg
);

   // A result holds until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_tx) && $stable(rsp_deg))
      else $error("stalled result changed");

   // Nothing is offered straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

   // A triangle without texture coordinates is never flagged degenerate and has no vectors.
   a_nouv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tvalid |-> !rsp_deg && rsp_tx == '0 && rsp_by == '0)
      else $error("result without texture coordinates is not empty");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deg |-> rsp_tvalid && rsp_tx == '0 && rsp_by == '0)
      else $error("degenerate result carries vectors");

endmodule

bind triangle_tangent_bitangent ttb_chk u_ttb_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_tx     (rsp_chan.tangent_x),
   .rsp_by     (rsp_chan.bitangent_y),
   .rsp_tvalid (rsp_chan.tangent_valid),
   .rsp_deg    (rsp_chan.degenerate)
);
`default_nettype wire
